// ----- rtl/core/trq_pkg.sv -----
// ----------------------------------------------------------------------------
// trq_pkg: touch report qualifier shared definitions
// Operation and register codes, reset values and the structs passed between
// the top level and the step logic.
// ----------------------------------------------------------------------------
package trq_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    OpPoll         = 3'd0,
    OpBlank        = 3'd1,
    OpWake         = 3'd2,
    OpPresenceOn   = 3'd3,
    OpBusRecovered = 3'd4,
    OpClearSwallow = 3'd5
  } op_e;

  localparam logic [1:0] BusOk = 2'd0;

  localparam logic [CfgIdxW-1:0] CfgSwallowTimeout = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGhostTimeout   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMoveThreshold  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFailLimit      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRecoverSettle  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStartupSettle  = 3'd5;

  localparam logic [MsW-1:0] SwallowTimeoutRst = 16'd300;
  localparam logic [MsW-1:0] GhostTimeoutRst   = 16'd2500;
  localparam logic [7:0]     MoveThresholdRst  = 8'd8;
  localparam logic [3:0]     FailLimitRst      = 4'd8;
  localparam logic [MsW-1:0] RecoverSettleRst  = 16'd200;
  localparam logic [MsW-1:0] StartupSettleRst  = 16'd1500;

  typedef struct packed {
    logic [MsW-1:0] swallow_timeout;
    logic [MsW-1:0] ghost_timeout;
    logic [7:0]     move_threshold;
    logic [3:0]     fail_limit;
    logic [MsW-1:0] recover_settle;
  } trq_cfg_t;

  typedef struct packed {
    logic              display_dark;
    logic              swallow;
    logic [TimeW-1:0]  swallow_start;
    logic [TimeW-1:0]  ready_deadline;
    logic              recover_pending;
    logic [3:0]        fail_count;
    logic              hold_valid;
    logic [TimeW-1:0]  hold_start;
    logic [CoordW-1:0] hold_x;
    logic [CoordW-1:0] hold_y;
    logic [CoordW-1:0] shown_x;
    logic [CoordW-1:0] shown_y;
  } trq_state_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [TimeW-1:0] now_ms;
    logic [1:0]       bus_status;
    logic [7:0]       contact_byte;
    logic [7:0]       x_high_byte;
    logic [7:0]       x_low_byte;
    logic [7:0]       y_high_byte;
    logic [7:0]       y_low_byte;
    logic             prone_flag;
  } trq_item_t;

  typedef struct packed {
    logic       pressed;
    logic [7:0] point_x;
    logic [8:0] point_y;
    logic       recover_request;
    logic       wake_request;
    logic       clear_prone;
    logic       screen_is_off;
  } trq_result_t;

  localparam trq_cfg_t CfgRst = '{
    swallow_timeout: SwallowTimeoutRst,
    ghost_timeout:   GhostTimeoutRst,
    move_threshold:  MoveThresholdRst,
    fail_limit:      FailLimitRst,
    recover_settle:  RecoverSettleRst
  };

  localparam trq_state_t StateRst = '{
    ready_deadline: {16'd0, StartupSettleRst},
    default:        '0
  };

endpackage

// ----- rtl/core/trq_in_if.sv -----
// ----------------------------------------------------------------------------
// trq_in_if: poll and event request channel
// Valid/ready channel carrying one operation with its time and poll bytes.
// ----------------------------------------------------------------------------
interface trq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] now_ms;
  logic [1:0]  bus_status;
  logic [7:0]  contact_byte;
  logic [7:0]  x_high_byte;
  logic [7:0]  x_low_byte;
  logic [7:0]  y_high_byte;
  logic [7:0]  y_low_byte;
  logic        prone_flag;

  modport source (
    output valid, operation, now_ms, bus_status, contact_byte,
           x_high_byte, x_low_byte, y_high_byte, y_low_byte, prone_flag,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, bus_status, contact_byte,
           x_high_byte, x_low_byte, y_high_byte, y_low_byte, prone_flag,
    output ready
  );
endinterface

// ----- rtl/core/trq_out_if.sv -----
// ----------------------------------------------------------------------------
// trq_out_if: pointer report channel
// Valid/ready channel carrying one qualified touch report.
// ----------------------------------------------------------------------------
interface trq_out_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic [7:0] point_x;
  logic [8:0] point_y;
  logic       recover_request;
  logic       wake_request;
  logic       clear_prone;
  logic       screen_is_off;

  modport source (
    output valid, pressed, point_x, point_y, recover_request, wake_request,
           clear_prone, screen_is_off,
    input  ready
  );
  modport sink (
    input  valid, pressed, point_x, point_y, recover_request, wake_request,
           clear_prone, screen_is_off,
    output ready
  );
endinterface

// ----- rtl/core/trq_step.sv -----
// ----------------------------------------------------------------------------
// trq_step: per-request qualification logic
// Computes the next tracker state and the report for one request.
// ----------------------------------------------------------------------------
module trq_step
  import trq_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  trq_item_t   item_i,
  input  trq_cfg_t    cfg_i,
  input  trq_state_t  state_i,
  output trq_state_t  state_o,
  output trq_result_t result_o
);

  localparam logic [CoordW:0]   WidthLim  = (CoordW+1)'(SCREEN_WIDTH);
  localparam logic [CoordW:0]   HeightLim = (CoordW+1)'(SCREEN_HEIGHT);
  localparam logic [CoordW-1:0] XMax      = CoordW'(SCREEN_WIDTH - 1);
  localparam logic [CoordW-1:0] YMax      = CoordW'(SCREEN_HEIGHT - 1);

  logic [CoordW-1:0] x_raw, y_raw, x, y, dx, dy;
  logic [3:0]        points;
  logic [3:0]        fail_next;
  logic [TimeW-1:0]  swallow_age, hold_age;
  logic              swallow_expired, ghost_expired, moved, not_ready;

  trq_state_t st;
  logic       pressed, wake, prone_clr;

  assign x_raw  = {item_i.x_high_byte[3:0], item_i.x_low_byte};
  assign y_raw  = {item_i.y_high_byte[3:0], item_i.y_low_byte};
  assign x      = ({1'b0, x_raw} >= WidthLim)  ? XMax : x_raw;
  assign y      = ({1'b0, y_raw} >= HeightLim) ? YMax : y_raw;
  assign points = item_i.contact_byte[3:0];

  assign dx    = (x > state_i.hold_x) ? x - state_i.hold_x : state_i.hold_x - x;
  assign dy    = (y > state_i.hold_y) ? y - state_i.hold_y : state_i.hold_y - y;
  assign moved = (dx > {4'd0, cfg_i.move_threshold}) ||
                 (dy > {4'd0, cfg_i.move_threshold});

  assign swallow_age     = item_i.now_ms - state_i.swallow_start;
  assign hold_age        = item_i.now_ms - state_i.hold_start;
  assign swallow_expired = swallow_age > {16'd0, cfg_i.swallow_timeout};
  assign ghost_expired   = hold_age > {16'd0, cfg_i.ghost_timeout};
  assign not_ready       = item_i.now_ms < state_i.ready_deadline;
  assign fail_next       = state_i.fail_count + 4'd1;

  always_comb begin
    st        = state_i;
    pressed   = 1'b0;
    wake      = 1'b0;
    prone_clr = 1'b0;
    unique case (item_i.operation)
      OpPoll: begin
        if (!state_i.recover_pending && !not_ready) begin
          if (item_i.bus_status != BusOk) begin
            if (fail_next >= cfg_i.fail_limit) begin
              st.fail_count      = 4'd0;
              st.recover_pending = 1'b1;
            end else begin
              st.fail_count = fail_next;
            end
            st.hold_valid = 1'b0;
            st.hold_start = '0;
          end else begin
            st.fail_count = 4'd0;
            if (state_i.display_dark || points == 4'd0) begin
              if (points == 4'd0) begin
                st.swallow       = 1'b0;
                st.swallow_start = '0;
              end else if (!state_i.swallow) begin
                wake = 1'b1;
              end
              st.hold_valid = 1'b0;
              st.hold_start = '0;
            end else begin
              if (state_i.swallow && swallow_expired) begin
                st.swallow       = 1'b0;
                st.swallow_start = '0;
              end
              if (!st.swallow) begin
                prone_clr = item_i.prone_flag;
                if (!state_i.hold_valid || moved) begin
                  st.hold_valid = 1'b1;
                  st.hold_start = item_i.now_ms;
                  st.hold_x     = x;
                  st.hold_y     = y;
                  pressed       = 1'b1;
                end else begin
                  pressed = !ghost_expired;
                end
                if (pressed) begin
                  st.shown_x = x;
                  st.shown_y = y;
                end
              end
            end
          end
        end
      end
      OpBlank: begin
        if (!state_i.display_dark) begin
          st.display_dark  = 1'b1;
          st.swallow       = 1'b1;
          st.swallow_start = item_i.now_ms;
        end
      end
      OpWake: begin
        if (state_i.display_dark) begin
          st.display_dark  = 1'b0;
          st.swallow       = 1'b1;
          st.swallow_start = item_i.now_ms;
        end
      end
      OpPresenceOn: begin
        st.display_dark = 1'b0;
      end
      OpBusRecovered: begin
        st.ready_deadline  = item_i.now_ms + {16'd0, cfg_i.recover_settle};
        st.recover_pending = 1'b0;
      end
      OpClearSwallow: begin
        st.swallow       = 1'b0;
        st.swallow_start = '0;
      end
      default: begin
      end
    endcase
  end

  assign state_o = st;

  assign result_o = '{
    pressed:         pressed,
    point_x:         st.shown_x[7:0],
    point_y:         st.shown_y[8:0],
    recover_request: st.recover_pending,
    wake_request:    wake,
    clear_prone:     prone_clr,
    screen_is_off:   st.display_dark
  };

endmodule

// ----- rtl/core/touch_report_qualifier.sv -----
// ----------------------------------------------------------------------------
// touch_report_qualifier: touch poll to pointer report qualifier
// Turns controller polls and screen events into pressed/released reports.
// ----------------------------------------------------------------------------
// Requests enter on req_i (valid/ready) and each one yields exactly one report
// on rsp_o (valid/ready). A request is captured in an input register; when the
// report register can advance, the step logic updates the tracker state and
// loads the report register, which offers the report on rsp_o. One request
// per cycle is sustained while the receiver takes reports; the step logic
// makes a single state update per request.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes one
// register per cycle; writing the startup settle register also reloads the
// ready deadline. Writes are expected only while no request is in flight.
// Reset clears both pipeline valid flags, loads the default configuration and
// arms the startup settle deadline. When the receiver stalls, the report
// register holds its value, the input register fills and req_i.ready drops.
// ----------------------------------------------------------------------------
module touch_report_qualifier
  import trq_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  trq_in_if.sink             req_i,
  trq_out_if.source          rsp_o
);

  trq_cfg_t    cfg_q;
  trq_state_t  state_q, state_d, step_state;
  trq_item_t   s1_item_q, req_item;
  logic        s1_valid_q, out_valid_q;
  trq_result_t out_q, step_result;
  logic        out_advance, s1_fire, req_fire;

  assign out_advance = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && out_advance;
  assign req_i.ready = !s1_valid_q || out_advance;
  assign req_fire    = req_i.valid && req_i.ready;

  assign req_item = '{
    operation:    req_i.operation,
    now_ms:       req_i.now_ms,
    bus_status:   req_i.bus_status,
    contact_byte: req_i.contact_byte,
    x_high_byte:  req_i.x_high_byte,
    x_low_byte:   req_i.x_low_byte,
    y_high_byte:  req_i.y_high_byte,
    y_low_byte:   req_i.y_low_byte,
    prone_flag:   req_i.prone_flag
  };

  trq_step #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_trq_step (
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (step_state),
    .result_o (step_result)
  );

  always_comb begin
    state_d = s1_fire ? step_state : state_q;
    if (cfg_we_i && cfg_idx_i == CfgStartupSettle) begin
      state_d.ready_deadline = {16'd0, cfg_wdata_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSwallowTimeout: cfg_q.swallow_timeout <= cfg_wdata_i;
        CfgGhostTimeout:   cfg_q.ghost_timeout   <= cfg_wdata_i;
        CfgMoveThreshold:  cfg_q.move_threshold  <= cfg_wdata_i[7:0];
        CfgFailLimit:      cfg_q.fail_limit      <= cfg_wdata_i[3:0];
        CfgRecoverSettle:  cfg_q.recover_settle  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_item_q <= req_item;
    end
    if (s1_fire) begin
      out_q <= step_result;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.pressed         = out_q.pressed;
  assign rsp_o.point_x         = out_q.point_x;
  assign rsp_o.point_y         = out_q.point_y;
  assign rsp_o.recover_request = out_q.recover_request;
  assign rsp_o.wake_request    = out_q.wake_request;
  assign rsp_o.clear_prone     = out_q.clear_prone;
  assign rsp_o.screen_is_off   = out_q.screen_is_off;

endmodule

// ----- rtl/core/trq_checker.sv -----
// ----------------------------------------------------------------------------
// trq_checker: touch report qualifier port checks
// Concurrent assertions on the request and report channels.
// ----------------------------------------------------------------------------
module trq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       pressed_i,
  input logic [7:0] point_x_i,
  input logic [8:0] point_y_i,
  input logic       recover_request_i,
  input logic       wake_request_i,
  input logic       clear_prone_i,
  input logic       screen_is_off_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({pressed_i, point_x_i, point_y_i, recover_request_i,
               wake_request_i, clear_prone_i, screen_is_off_i}))
    else $error("report changed while stalled");

  a_wake_not_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(pressed_i && wake_request_i))
    else $error("wake request on a pressed report");

  a_press_context: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pressed_i |-> !screen_is_off_i && !recover_request_i)
    else $error("press reported while screen off or recovery pending");

  a_report_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("report without a matching request");

endmodule

bind touch_report_qualifier trq_checker u_trq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .pressed_i         (rsp_o.pressed),
  .point_x_i         (rsp_o.point_x),
  .point_y_i         (rsp_o.point_y),
  .recover_request_i (rsp_o.recover_request),
  .wake_request_i    (rsp_o.wake_request),
  .clear_prone_i     (rsp_o.clear_prone),
  .screen_is_off_i   (rsp_o.screen_is_off)
);

// ----- bench/touch_report_qualifier_test.sv -----
// ----------------------------------------------------------------------------
// touch_report_qualifier_test: touch report qualifier testbench
// Sends polls and screen events over the request channel and keeps a
// transaction-level tracker of the qualifier state alongside the block. Each
// accepted request yields one predicted report. Reports are compared in order,
// field by field. The run covers directed corner cases, then random sessions
// under several register settings and traffic patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_report_qualifier_test
  import trq_pkg::*;
;

  localparam int unsigned ScreenW    = 240;
  localparam int unsigned ScreenH    = 320;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NumPhases  = 6;

  class report_scoreboard;
    logic [31:0] swallow_to, ghost_to, move_thr, recover_settle;
    logic [3:0]  fail_lim;
    logic        display_dark, swallow, recover_pending, hold_valid;
    logic [31:0] swallow_start, ready_deadline, hold_start;
    logic [3:0]  fail_count;
    logic [CoordW-1:0] hold_x, hold_y, shown_x, shown_y;
    trq_result_t expected_reports[$];
    int unsigned requests_noted = 0;
    int unsigned reports_checked = 0;
    int unsigned presses_seen = 0;
    int unsigned failures = 0;

    function new();
      swallow_to      = 32'(SwallowTimeoutRst);
      ghost_to        = 32'(GhostTimeoutRst);
      move_thr        = 32'(MoveThresholdRst);
      fail_lim        = FailLimitRst;
      recover_settle  = 32'(RecoverSettleRst);
      ready_deadline  = 32'(StartupSettleRst);
      display_dark    = 1'b0;
      swallow         = 1'b0;
      swallow_start   = '0;
      recover_pending = 1'b0;
      fail_count      = '0;
      hold_valid      = 1'b0;
      hold_start      = '0;
      hold_x          = '0;
      hold_y          = '0;
      shown_x         = '0;
      shown_y         = '0;
    endfunction

    function void load_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgSwallowTimeout: swallow_to = 32'(data);
        CfgGhostTimeout:   ghost_to = 32'(data);
        CfgMoveThreshold:  move_thr = 32'(data[7:0]);
        CfgFailLimit:      fail_lim = data[3:0];
        CfgRecoverSettle:  recover_settle = 32'(data);
        CfgStartupSettle:  ready_deadline = 32'(data);
        default: ;
      endcase
    endfunction

    function logic [31:0] coord_gap(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void release_hold();
      hold_valid = 1'b0;
      hold_start = '0;
    endfunction

    function void note_request(trq_item_t it);
      trq_result_t rep;
      logic [CoordW-1:0] x, y;
      logic [31:0] t;
      rep = '0;
      t = it.now_ms;
      case (it.operation)
        OpPoll: begin
          if (!recover_pending && t >= ready_deadline) begin
            if (it.bus_status != BusOk) begin
              fail_count = fail_count + 4'd1;
              if (fail_count >= fail_lim) begin
                fail_count = '0;
                recover_pending = 1'b1;
              end
              release_hold();
            end else begin
              fail_count = '0;
              if (it.contact_byte[3:0] == 4'd0) begin
                swallow = 1'b0;
                swallow_start = '0;
                release_hold();
              end else if (display_dark) begin
                rep.wake_request = !swallow;
                release_hold();
              end else begin
                if (swallow && (t - swallow_start) > swallow_to) begin
                  swallow = 1'b0;
                  swallow_start = '0;
                end
                if (!swallow) begin
                  x = {it.x_high_byte[3:0], it.x_low_byte};
                  y = {it.y_high_byte[3:0], it.y_low_byte};
                  if (x >= 12'(ScreenW)) x = 12'(ScreenW - 1);
                  if (y >= 12'(ScreenH)) y = 12'(ScreenH - 1);
                  rep.clear_prone = it.prone_flag;
                  rep.pressed = 1'b1;
                  if (!hold_valid || coord_gap(32'(x), 32'(hold_x)) > move_thr ||
                      coord_gap(32'(y), 32'(hold_y)) > move_thr) begin
                    hold_valid = 1'b1;
                    hold_start = t;
                    hold_x = x;
                    hold_y = y;
                  end else if ((t - hold_start) > ghost_to) begin
                    rep.pressed = 1'b0;
                  end
                  if (rep.pressed) begin
                    shown_x = x;
                    shown_y = y;
                  end
                end
              end
            end
          end
        end
        OpBlank: begin
          if (!display_dark) begin
            display_dark = 1'b1;
            swallow = 1'b1;
            swallow_start = t;
          end
        end
        OpWake: begin
          if (display_dark) begin
            display_dark = 1'b0;
            swallow = 1'b1;
            swallow_start = t;
          end
        end
        OpPresenceOn: display_dark = 1'b0;
        OpBusRecovered: begin
          ready_deadline = t + recover_settle;
          recover_pending = 1'b0;
        end
        OpClearSwallow: begin
          swallow = 1'b0;
          swallow_start = '0;
        end
        default: ;
      endcase
      rep.point_x = shown_x[7:0];
      rep.point_y = shown_y[8:0];
      rep.recover_request = recover_pending;
      rep.screen_is_off = display_dark;
      expected_reports.push_back(rep);
      requests_noted++;
    endfunction

    function void check_report(trq_result_t got);
      trq_result_t want;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("report %0d arrived with no request outstanding", reports_checked);
      end else begin
        want = expected_reports.pop_front();
        if (want.pressed) presses_seen++;
        if (got.pressed !== want.pressed || got.point_x !== want.point_x ||
            got.point_y !== want.point_y || got.recover_request !== want.recover_request ||
            got.wake_request !== want.wake_request || got.clear_prone !== want.clear_prone ||
            got.screen_is_off !== want.screen_is_off) begin
          failures++;
          if (failures <= 10) begin
            $display("report %0d mismatch: expected pressed %0b x %0d y %0d rec %0b",
                     reports_checked, want.pressed, want.point_x, want.point_y,
                     want.recover_request);
            $display("  expected wake %0b prone %0b off %0b",
                     want.wake_request, want.clear_prone, want.screen_is_off);
            $display("  got pressed %0b x %0d y %0d rec %0b wake %0b prone %0b off %0b",
                     got.pressed, got.point_x, got.point_y, got.recover_request,
                     got.wake_request, got.clear_prone, got.screen_is_off);
          end
        end
      end
      reports_checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  trq_in_if  req_if ();
  trq_out_if rsp_if ();

  touch_report_qualifier #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  report_scoreboard sb = new();
  int unsigned tx_idle_pct = 35;
  int unsigned rx_idle_pct = 85;
  int unsigned rx_hold = 0;
  int unsigned settings_used = 1;
  logic [31:0] ms_now;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        sb.check_report(trq_result_t'({rsp_if.pressed, rsp_if.point_x, rsp_if.point_y,
                                       rsp_if.recover_request, rsp_if.wake_request,
                                       rsp_if.clear_prone, rsp_if.screen_is_off}));
      if (rx_hold != 0) begin
        rsp_if.ready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no request or report moved for %0d cycles", StallLimit);
    $display("simulation failed");
    $finish;
  end

  task automatic send_request(input trq_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    {req_if.operation, req_if.now_ms, req_if.bus_status, req_if.contact_byte,
     req_if.x_high_byte, req_if.x_low_byte, req_if.y_high_byte, req_if.y_low_byte,
     req_if.prone_flag} <= it;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(it);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.load_register(idx, data);
  endtask

  task automatic apply_settings(input logic [CfgW-1:0] swallow_ms, ghost_ms, move_px,
                                input logic [CfgW-1:0] fails, recover_ms, startup_ms);
    write_register(CfgSwallowTimeout, swallow_ms);
    write_register(CfgGhostTimeout, ghost_ms);
    write_register(CfgMoveThreshold, move_px);
    write_register(CfgFailLimit, fails);
    write_register(CfgRecoverSettle, recover_ms);
    write_register(CfgStartupSettle, startup_ms);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic trq_item_t poll_item(input logic [1:0] status, input logic [3:0] contacts,
                                          input logic [11:0] x, input logic [11:0] y,
                                          input logic prone);
    trq_item_t it;
    it.operation    = OpPoll;
    it.now_ms       = ms_now;
    it.bus_status   = status;
    it.contact_byte = {4'($urandom_range(15)), contacts};
    it.x_high_byte  = {4'($urandom_range(15)), x[11:8]};
    it.x_low_byte   = x[7:0];
    it.y_high_byte  = {4'($urandom_range(15)), y[11:8]};
    it.y_low_byte   = y[7:0];
    it.prone_flag   = prone;
    return it;
  endfunction

  function automatic trq_item_t event_item(input logic [2:0] op);
    trq_item_t it;
    it = 78'({$urandom, $urandom, $urandom});
    it.operation = op;
    it.now_ms = ms_now;
    return it;
  endfunction

  function automatic logic [11:0] jitter(input logic [11:0] base, input int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic touch_drag();
    int unsigned span;
    logic [11:0] bx, by;
    span = ($urandom_range(3) == 0) ? 40 : int'(sb.move_thr) + 2;
    bx = ($urandom_range(1) == 1) ? 12'($urandom_range(ScreenW - 1)) : 12'($urandom);
    by = ($urandom_range(1) == 1) ? 12'($urandom_range(ScreenH - 1)) : 12'($urandom);
    repeat ($urandom_range(12, 3)) begin
      if (sb.hold_valid && $urandom_range(5) == 0)
        ms_now = sb.hold_start + sb.ghost_to + $urandom_range(1);
      else
        ms_now += $urandom_range(60, 1);
      send_request(poll_item(($urandom_range(9) == 0) ? 2'($urandom_range(3, 1)) : BusOk,
                             4'($urandom_range(15, 1)), jitter(bx, span), jitter(by, span),
                             1'($urandom_range(1))));
    end
    if ($urandom_range(1) == 1) begin
      ms_now += $urandom_range(60, 1);
      send_request(poll_item(BusOk, 4'd0, 12'($urandom), 12'($urandom), 1'($urandom_range(1))));
    end
  endtask

  task automatic screen_cycle();
    ms_now += $urandom_range(50, 1);
    send_request(event_item(OpBlank));
    repeat ($urandom_range(4, 1)) begin
      ms_now += $urandom_range(80, 1);
      send_request(poll_item(BusOk, 4'($urandom_range(2)), 12'($urandom), 12'($urandom),
                             1'($urandom_range(1))));
    end
    ms_now += $urandom_range(80, 1);
    send_request(event_item(($urandom_range(3) == 0) ? OpPresenceOn : OpWake));
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(2) == 0)
        ms_now = sb.swallow_start + sb.swallow_to + $urandom_range(1);
      else
        ms_now += $urandom_range(120, 1);
      if ($urandom_range(7) == 0)
        send_request(event_item(OpClearSwallow));
      else
        send_request(poll_item(BusOk, 4'($urandom_range(3)), 12'($urandom_range(300)),
                               12'($urandom_range(400)), 1'($urandom_range(1))));
    end
  endtask

  task automatic bus_faults();
    repeat ($urandom_range(16, 1)) begin
      ms_now += $urandom_range(30, 1);
      send_request(poll_item(($urandom_range(7) == 0) ? BusOk : 2'($urandom_range(3, 1)),
                             4'($urandom_range(15)), 12'($urandom), 12'($urandom),
                             1'($urandom_range(1))));
    end
    ms_now += $urandom_range(30, 1);
    send_request(event_item(OpBusRecovered));
    ms_now = sb.ready_deadline - $urandom_range(1);
    send_request(poll_item(BusOk, 4'd1, 12'($urandom_range(ScreenW - 1)),
                           12'($urandom_range(ScreenH - 1)), 1'($urandom_range(1))));
  endtask

  task automatic noise_items();
    trq_item_t it;
    repeat ($urandom_range(3, 1)) begin
      it = 78'({$urandom, $urandom, $urandom});
      if ($urandom_range(1) == 1) it.now_ms = ms_now;
      send_request(it);
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = sb.requests_noted;
    while (sb.requests_noted - start < count) begin
      // get past pending recovery, settle time and a dark screen most of the time
      if (sb.recover_pending && $urandom_range(3) != 0) begin
        send_request(event_item(OpBusRecovered));
        ms_now = sb.ready_deadline;
      end
      if (ms_now < sb.ready_deadline && $urandom_range(7) != 0)
        ms_now = sb.ready_deadline + $urandom_range(3);
      if (sb.display_dark && $urandom_range(3) != 0)
        send_request(event_item(OpPresenceOn));
      pick = $urandom_range(99);
      if (pick < 45) begin
        touch_drag();
      end else if (pick < 65) begin
        screen_cycle();
      end else if (pick < 78) begin
        bus_faults();
      end else if (pick < 90) begin
        noise_items();
      end else if (pick < 95) begin
        send_request(event_item(($urandom_range(1) == 1) ? OpPresenceOn : OpClearSwallow));
      end else begin
        // cross the 32-bit wrap of the millisecond counter
        ms_now = 32'hFFFF_FFFF - $urandom_range(400);
        send_request(event_item(OpBusRecovered));
        touch_drag();
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    {req_if.operation, req_if.now_ms, req_if.bus_status, req_if.contact_byte,
     req_if.x_high_byte, req_if.x_low_byte, req_if.y_high_byte, req_if.y_low_byte,
     req_if.prone_flag} <= '0;
    ms_now = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ms_now = 32'd0;
    send_request(poll_item(BusOk, 4'd1, 12'd100, 12'd100, 1'b1));
    ms_now = 32'd1500;
    send_request(poll_item(BusOk, 4'd15, 12'hFFF, 12'hFFF, 1'b1));
    ms_now = 32'd1510;
    send_request(poll_item(BusOk, 4'd1, 12'd0, 12'd0, 1'b0));
    ms_now = 32'd1520;
    send_request(poll_item(BusOk, 4'd1, 12'd8, 12'd8, 1'b0));
    ms_now = 32'd4010;
    send_request(poll_item(BusOk, 4'd1, 12'd8, 12'd8, 1'b0));
    ms_now = 32'd4011;
    send_request(poll_item(BusOk, 4'd1, 12'd8, 12'd8, 1'b0));
    ms_now = 32'd4020;
    send_request(poll_item(BusOk, 4'd0, 12'd8, 12'd8, 1'b0));
    for (int k = 0; k < 8; k++) begin
      ms_now += 32'd1;
      send_request(poll_item(2'(k % 3 + 1), 4'd1, 12'd50, 12'd50, 1'b0));
    end
    ms_now = 32'd4100;
    send_request(event_item(OpBusRecovered));
    ms_now = 32'd4300;
    send_request(poll_item(BusOk, 4'd1, 12'd239, 12'd319, 1'b0));
    ms_now = 32'd4400;
    send_request(event_item(OpBlank));
    ms_now = 32'd4410;
    send_request(poll_item(BusOk, 4'd1, 12'd20, 12'd20, 1'b0));
    ms_now = 32'd4420;
    send_request(poll_item(BusOk, 4'd0, 12'd20, 12'd20, 1'b0));
    ms_now = 32'd4430;
    send_request(poll_item(BusOk, 4'd2, 12'd20, 12'd20, 1'b0));
    ms_now = 32'd4500;
    send_request(event_item(OpWake));
    ms_now = 32'd4800;
    send_request(poll_item(BusOk, 4'd1, 12'd240, 12'd320, 1'b1));
    ms_now = 32'd4801;
    send_request(poll_item(BusOk, 4'd1, 12'd240, 12'd320, 1'b1));
    send_request(event_item(OpPresenceOn));
    send_request(event_item(OpClearSwallow));
    send_request(event_item(3'd6));
    send_request(event_item(3'd7));
    ms_now = 32'hFFFF_FFF0;
    send_request(event_item(OpBusRecovered));
    ms_now = 32'hFFFF_FFF8;
    send_request(poll_item(BusOk, 4'd1, 12'd10, 12'd10, 1'b0));
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 3)
        0: begin tx_idle_pct = 35; rx_idle_pct = 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct = 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (p)
        0: apply_settings(16'd40, 16'd150, 16'd4, 16'd3, 16'd30, 16'd0);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: apply_settings(16'($urandom_range(600)), 16'($urandom_range(3000)),
                          16'($urandom_range(24)), 16'($urandom_range(15, 1)),
                          16'($urandom_range(400)), 16'($urandom_range(2000)));
        4: apply_settings(SwallowTimeoutRst, GhostTimeoutRst, 16'(MoveThresholdRst),
                          16'(FailLimitRst), RecoverSettleRst, StartupSettleRst);
        default: apply_settings(16'($urandom_range(100)), 16'($urandom_range(400)),
                                16'($urandom), 16'd1, 16'($urandom), 16'($urandom));
      endcase
      ms_now = sb.ready_deadline;
      if (p == 2) begin
        run_phase(50);
        // hold the report side while requests keep coming
        rx_hold = 400;
        run_phase(65);
      end else if (p == 4) begin
        run_phase(55);
        wait_drained();
        run_phase(60);
      end else begin
        run_phase(115);
      end
      wait_drained();
    end

    sb.failures += sb.expected_reports.size();
    $display("%0d requests under %0d register settings, %0d reports checked (%0d pressed)",
             sb.requests_noted, settings_used, sb.reports_checked, sb.presses_seen);
    $display("sessions: drags, blank and wake, bus fault streaks, clock wrap and raw noise");
    if (sb.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
